### design/dttf_pkg.sv
// shared types, token and status codes and the fraction table for the decimal parser
package dttf_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_BLANK = 3'd0;
    localparam logic [2:0] KIND_PLUS  = 3'd1;
    localparam logic [2:0] KIND_MINUS = 3'd2;
    localparam logic [2:0] KIND_DIGIT = 3'd3;
    localparam logic [2:0] KIND_POINT = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;
    localparam logic [2:0] KIND_END   = 3'd6;

    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_BAD   = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
    } token_t;

    // 10^-(idx+1) in unsigned q0.32, rounded to nearest
    function automatic logic [31:0] tenth_pow(input logic [3:0] idx);
        logic [31:0] r;
        begin
            unique case (idx)
                4'd0:    r = 32'd429496730;
                4'd1:    r = 32'd42949673;
                4'd2:    r = 32'd4294967;
                4'd3:    r = 32'd429497;
                4'd4:    r = 32'd42950;
                4'd5:    r = 32'd4295;
                4'd6:    r = 32'd429;
                4'd7:    r = 32'd43;
                4'd8:    r = 32'd4;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### design/decimal_text_to_fixed.sv
// top level of the ascii decimal to signed fixed point parser
// Takes one text byte per beat and returns one signed Q(INT_BITS).(FRAC_BITS) value with a
// status (ok, bad character, saturated) for every zero byte. A new byte is taken every cycle
// while the token queue is not full; the rate is set by the parser's one-token-per-cycle
// state update. A classifier tags each byte and writes it into a two-entry token queue, so
// bytes keep flowing while a result waits in the output register. A zero byte's token is
// queued, then its result is registered. Fraction digits beyond FRAC_DIGITS are ignored.
module decimal_text_to_fixed #(
    parameter int INT_BITS    = 16,
    parameter int FRAC_BITS   = 16,
    parameter int FRAC_DIGITS = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] fixed_value,
    output logic [1:0]         status
);
    import dttf_pkg::*;

    token_t front_token;
    token_t head_token;
    logic   queue_full;
    logic   head_valid;
    logic   pop;

    assign in_stall = queue_full;

    dttf_front u_front (
        .char_code (char_code),
        .token     (front_token)
    );

    dttf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_token (front_token),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    dttf_back #(
        .INT_BITS    (INT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_token  (head_token),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fixed_value (fixed_value),
        .status      (status)
    );

endmodule

### design/dttf_front.sv
// character classifier that turns each text byte into a parser token
module dttf_front (
    input  logic [7:0]      char_code,
    output dttf_pkg::token_t token
);
    import dttf_pkg::*;

    always_comb
    begin
        token.digit = char_code[3:0];
        priority if (char_code == 8'h00)
        begin
            token.kind = KIND_END;
        end
        else if (char_code == 8'h20 || char_code == 8'h09)
        begin
            token.kind = KIND_BLANK;
        end
        else if (char_code == 8'h2B)
        begin
            token.kind = KIND_PLUS;
        end
        else if (char_code == 8'h2D)
        begin
            token.kind = KIND_MINUS;
        end
        else if (char_code == 8'h2E)
        begin
            token.kind = KIND_POINT;
        end
        else if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            token.kind = KIND_DIGIT;
        end
        else
        begin
            token.kind = KIND_OTHER;
        end
    end

endmodule

### design/dttf_queue.sv
// short token queue between the classifier and the parser
module dttf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dttf_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output dttf_pkg::token_t head_token
);
    import dttf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

### design/dttf_back.sv
// parser state, digit accumulators, result formatting and output register
module dttf_back #(
    parameter int INT_BITS    = 16,
    parameter int FRAC_BITS   = 16,
    parameter int FRAC_DIGITS = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  dttf_pkg::token_t   head_token,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] fixed_value,
    output logic [1:0]         status
);
    import dttf_pkg::*;

    localparam int IW    = INT_BITS - 1;
    localparam int MAG_W = INT_BITS + FRAC_BITS;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic              neg_reg;
    logic              neg_next;
    logic [IW-1:0]     int_reg;
    logic [IW-1:0]     int_next;
    logic [31:0]       frac_reg;
    logic [31:0]       frac_next;
    logic [3:0]        pos_reg;
    logic [3:0]        pos_next;
    logic              sat_reg;
    logic              sat_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       value_reg;
    logic [31:0]       value_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    logic              out_ready;
    logic              is_end;
    logic              take;
    logic [IW+3:0]     int_sum;
    logic              int_over;
    logic [35:0]       frac_sum;
    logic [MAG_W-1:0]  mag;
    logic [63:0]       mag_wide;
    logic [31:0]       mag_clamped;
    logic              clamp;

    assign out_ready   = !out_valid_reg || !out_stall;
    assign is_end      = (head_token.kind == KIND_END);
    assign pop         = head_valid && (!is_end || out_ready);
    assign take        = pop;
    assign out_valid   = out_valid_reg;
    assign fixed_value = value_reg;
    assign status      = status_reg;

    // integer digit: acc * 10 + d, saturating
    assign int_sum  = {int_reg, 3'b000} + {2'b00, int_reg, 1'b0} + (IW+4)'(head_token.digit);
    assign int_over = (int_sum > (IW+4)'({IW{1'b1}}));

    // fraction digit: acc + d * 10^-k, saturating
    assign frac_sum = {4'b0000, frac_reg} + (36'(head_token.digit) * 36'(tenth_pow(pos_reg)));

    // magnitude before the output clamp
    always_comb
    begin
        if (sat_reg)
        begin
            mag = (MAG_W'(1) << (MAG_W - 1)) - MAG_W'(!neg_reg);
        end
        else
        begin
            mag = MAG_W'({int_reg, {FRAC_BITS{1'b0}}}) | MAG_W'(frac_reg >> (32 - FRAC_BITS));
        end
        mag_wide = 64'(mag);
        if (neg_reg)
        begin
            clamp       = (mag_wide > 64'h0000_0000_8000_0000);
            mag_clamped = clamp ? 32'h8000_0000 : mag_wide[31:0];
        end
        else
        begin
            clamp       = (mag_wide > 64'h0000_0000_7FFF_FFFF);
            mag_clamped = clamp ? 32'h7FFF_FFFF : mag_wide[31:0];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        pos_next       = pos_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;

        if (take)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                if (phase_reg == PH_BAD)
                begin
                    value_next  = 32'd0;
                    status_next = ST_BAD;
                end
                else
                begin
                    value_next  = neg_reg ? 32'd0 - mag_clamped : mag_clamped;
                    status_next = (sat_reg || clamp) ? ST_SAT : ST_OK;
                end
                phase_next = PH_BLANK;
                neg_next   = 1'b0;
                int_next   = '0;
                frac_next  = '0;
                pos_next   = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BLANK:
                    begin
                        priority if (head_token.kind == KIND_BLANK)
                        begin
                            phase_next = PH_BLANK;
                        end
                        else if (head_token.kind == KIND_PLUS || head_token.kind == KIND_MINUS)
                        begin
                            neg_next   = (head_token.kind == KIND_MINUS);
                            phase_next = PH_INT;
                        end
                        else if (head_token.kind == KIND_DIGIT)
                        begin
                            int_next   = int_over ? {IW{1'b1}} : int_sum[IW-1:0];
                            sat_next   = sat_reg || int_over;
                            phase_next = PH_INT;
                        end
                        else if (head_token.kind == KIND_POINT)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_INT:
                    begin
                        priority if (head_token.kind == KIND_DIGIT)
                        begin
                            int_next = int_over ? {IW{1'b1}} : int_sum[IW-1:0];
                            sat_next = sat_reg || int_over;
                        end
                        else if (head_token.kind == KIND_POINT)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (head_token.kind == KIND_DIGIT)
                        begin
                            if (pos_reg < 4'(FRAC_DIGITS))
                            begin
                                frac_next = (frac_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                      : frac_sum[31:0];
                                pos_next  = pos_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_BAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BLANK;
            neg_reg       <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            pos_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            pos_reg       <= pos_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

### sim/decimal_text_to_fixed_tb.sv
// self-checking testbench for the decimal text to fixed point parser
`timescale 1ns / 1ps

import dttf_pkg::*;

class number_scoreboard;
    localparam int INT_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int FRAC_DIGS = 9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic [1:0]         phase;
    bit                 negative;
    longint unsigned    int_part;
    longint unsigned    frac_q32;
    int unsigned        frac_count;
    bit                 saturated;
    longint unsigned    tenth_q32 [9];
    logic signed [31:0] expected_values [$];
    logic [1:0]         expected_statuses [$];
    int                 errors;

    function new();
        tenth_q32[0] = 429496730;
        tenth_q32[1] = 42949673;
        tenth_q32[2] = 4294967;
        tenth_q32[3] = 429497;
        tenth_q32[4] = 42950;
        tenth_q32[5] = 4295;
        tenth_q32[6] = 429;
        tenth_q32[7] = 43;
        tenth_q32[8] = 4;
        errors = 0;
        restart();
    endfunction

    function void restart();
        phase      = PH_BLANK;
        negative   = 1'b0;
        int_part   = 0;
        frac_q32   = 0;
        frac_count = 0;
        saturated  = 1'b0;
    endfunction

    function int pending();
        return expected_values.size();
    endfunction

    function void add_int_digit(int unsigned d);
        longint unsigned v;
        v = int_part * 10 + d;
        if (v > (64'd1 << (INT_W - 1)) - 1) begin
            v = (64'd1 << (INT_W - 1)) - 1;
            saturated = 1'b1;
        end
        int_part = v;
    endfunction

    function void add_frac_digit(int unsigned d);
        longint unsigned s;
        if (frac_count < FRAC_DIGS) begin
            s = frac_q32 + d * tenth_q32[frac_count];
            if (s > 64'hFFFF_FFFF)
                s = 64'hFFFF_FFFF;
            frac_q32 = s;
            frac_count++;
        end
    endfunction

    function void close_number();
        longint unsigned mag;
        logic [31:0]     value;
        logic [1:0]      st;
        st = ST_OK;
        if (phase == PH_BAD) begin
            value = '0;
            st    = ST_BAD;
        end
        else begin
            if (saturated) begin
                mag = 64'd1 << (INT_W - 1 + FRAC_W);
                if (!negative)
                    mag = mag - 1;
                st = ST_SAT;
            end
            else
                mag = (int_part << FRAC_W) + (frac_q32 >> (32 - FRAC_W));
            if (negative) begin
                if (mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                    st  = ST_SAT;
                end
                value = 32'(64'd0 - mag);
            end
            else begin
                if (mag > 64'h7FFF_FFFF) begin
                    mag = 64'h7FFF_FFFF;
                    st  = ST_SAT;
                end
                value = 32'(mag);
            end
        end
        expected_values.push_back(value);
        expected_statuses.push_back(st);
        restart();
    endfunction

    // one accepted input beat
    function void take_char(logic [7:0] c);
        bit          is_digit;
        int unsigned d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = c - CH_ZERO;
        if (c == CH_NUL) begin
            close_number();
            return;
        end
        case (phase)
            PH_BLANK:
            begin
                if (c == CH_SPACE || c == CH_TAB) begin
                end
                else if (c == CH_PLUS || c == CH_MINUS) begin
                    negative = (c == CH_MINUS);
                    phase    = PH_INT;
                end
                else if (is_digit) begin
                    add_int_digit(d);
                    phase = PH_INT;
                end
                else if (c == CH_POINT)
                    phase = PH_FRAC;
                else
                    phase = PH_BAD;
            end
            PH_INT:
            begin
                if (is_digit)
                    add_int_digit(d);
                else if (c == CH_POINT)
                    phase = PH_FRAC;
                else
                    phase = PH_BAD;
            end
            PH_FRAC:
            begin
                if (is_digit)
                    add_frac_digit(d);
                else
                    phase = PH_BAD;
            end
            default:
            begin
            end
        endcase
    endfunction

    // one accepted output beat
    function void check_number(logic signed [31:0] got_value, logic [1:0] got_status);
        logic signed [31:0] want_value;
        logic [1:0]         want_status;
        if (expected_values.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", $time, got_value,
                     got_status);
            errors++;
            return;
        end
        want_value  = expected_values.pop_front();
        want_status = expected_statuses.pop_front();
        if (got_value !== want_value) begin
            $display("%0t: fixed_value expected %h actual %h", $time, want_value, got_value);
            errors++;
        end
        if (got_status !== want_status) begin
            $display("%0t: status expected %0d actual %0d", $time, want_status, got_status);
            errors++;
        end
    endfunction
endclass

module decimal_text_to_fixed_tb;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int ITEMS_PER_PHASE = 400;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         char_code;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] fixed_value;
    logic [1:0]         status;

    number_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               chars_sent;
    bit               hold_go;
    int               hold_left;
    int               quiet_cycles;

    decimal_text_to_fixed #(
        .INT_BITS    (16),
        .FRAC_BITS   (16),
        .FRAC_DIGITS (9)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fixed_value (fixed_value),
        .status      (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.take_char(char_code);
            if (out_valid && !out_stall)
                sb.check_number(fixed_value, status);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_number();
        logic [7:0] text [$];
        int         n_int;
        int         n_frac;
        int         k;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6))
                text.push_back(8'($urandom_range(1, 255)));
        end
        else begin
            repeat ($urandom_range(0, 2))
                text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(2))
                1: text.push_back(CH_PLUS);
                2: text.push_back(CH_MINUS);
                default:
                begin
                end
            endcase
            n_int = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
            repeat (n_int)
                text.push_back(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(2) != 0) begin
                text.push_back(CH_POINT);
                n_frac = ($urandom_range(7) == 0) ? $urandom_range(10, 13)
                                                  : $urandom_range(0, 5);
                repeat (n_frac)
                    text.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            // broken sequence: one character replaced
            if (text.size() > 0 && $urandom_range(9) < 2) begin
                k = $urandom_range(text.size() - 1);
                case ($urandom_range(5))
                    0: text[k] = CH_SPACE;
                    1: text[k] = CH_PLUS;
                    2: text[k] = CH_MINUS;
                    3: text[k] = CH_POINT;
                    default: text[k] = 8'($urandom_range(1, 255));
                endcase
            end
        end
        foreach (text[i])
            send_char(text[i]);
        send_char(CH_NUL);
    endtask

    initial
    begin
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        char_code      = 8'h00;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        chars_sent     = 0;
        hold_go        = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("");
        send_text(" \t");
        send_text("-");
        send_text(".");
        send_text("-32768");
        send_text("-1.5");
        send_text("7a");
        send_char(8'hFF);
        send_char(CH_NUL);
        wait_drain();

        // output held off while short numbers keep coming
        hold_go = 1'b1;
        repeat (20)
            send_text("1");
        wait_drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            chars_sent = 0;
            while (chars_sent < ITEMS_PER_PHASE)
                send_random_number();
            wait_drain();
        end

        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
